@@ rtl/core/ccsp_pkg.sv @@
`default_nettype none

package ccsp_pkg;

    // default field sizes of the apE section, in bytes
    localparam int unsigned APE_COUNT_BYTES_DEF = 2;
    localparam int unsigned APE_ID_BYTES_DEF    = 2;
    localparam int unsigned OPCODE_BYTES_DEF    = 2;
    localparam int unsigned COST_BYTES_DEF      = 2;
    localparam int unsigned TIME_BYTES_DEF      = 2;

    // fixed layout of the stream
    localparam int unsigned DO_WIDE_BYTES = 4;
    localparam int unsigned HDR_WIDE_BYTES = 2;
    localparam int unsigned MAX_RES = 4;

    // field codes
    typedef enum logic [4:0] {
        F_LCF          = 5'd0,
        F_NAF          = 5'd1,
        F_TASK_ID      = 5'd2,
        F_RPI_VERSION  = 5'd3,
        F_REF_ID       = 5'd4,
        F_IMPL_VERSION = 5'd5,
        F_DEV_ID       = 5'd6,
        F_CREATE_DATE  = 5'd7,
        F_DO_COUNT     = 5'd8,
        F_DO_ID        = 5'd9,
        F_DO_SIZE      = 5'd10,
        F_DO_ACCESS_T  = 5'd11,
        F_DATA_LEN     = 5'd12,
        F_DATA_BYTE    = 5'd13,
        F_ASF_DO       = 5'd14,
        F_PAIR_COUNT   = 5'd15,
        F_PAIR_APE     = 5'd16,
        F_PAIR_PORT    = 5'd17,
        F_APE_COUNT    = 5'd18,
        F_APE_ID       = 5'd19,
        F_OPCODE       = 5'd20,
        F_T_BIT        = 5'd21,
        F_NN           = 5'd22,
        F_COST         = 5'd23,
        F_TIME         = 5'd24,
        F_ACCESS_TYPE  = 5'd25
    } t_field;

    typedef struct packed {
        t_field      code;
        logic [15:0] entity;
        logic [7:0]  element;
        logic [31:0] value;
    } t_result;

    function automatic t_result mk_result(t_field code, logic [15:0] entity,
                                          logic [7:0] element, logic [31:0] value);
        t_result r;
        r.code    = code;
        r.entity  = entity;
        r.element = element;
        r.value   = value;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/config_code_stream_parser.sv @@
// path: a taken byte is held in the input register, then parsed into the result buffer,
//   whose first beat drives the outputs; a burst not yet drained holds the parse back
// throughput: one byte per cycle while each byte yields at most one result beat and
//   the receiver does not stall; a byte with more beats holds the parse stage until its last beat leaves
// reset: i_rst_n is synchronous, active low; it returns the parser to the control header
`default_nettype none

module config_code_stream_parser
    import ccsp_pkg::*;
#(
    parameter int unsigned APE_COUNT_BYTES = APE_COUNT_BYTES_DEF,
    parameter int unsigned APE_ID_BYTES    = APE_ID_BYTES_DEF,
    parameter int unsigned OPCODE_BYTES    = OPCODE_BYTES_DEF,
    parameter int unsigned COST_BYTES      = COST_BYTES_DEF,
    parameter int unsigned TIME_BYTES      = TIME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream in
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_cfg_byte,
    // result beats out
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_field_code,
    output logic [15:0]      o_entity_index,
    output logic [7:0]       o_element_index,
    output logic [31:0]      o_field_value,
    output logic             o_last_of_run,
    output logic             o_parse_done
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DO_CNT  = 3'd1,
        PH_DO      = 3'd2,
        PH_ASF     = 3'd3,
        PH_APE_CNT = 3'd4,
        PH_APE     = 3'd5
    } t_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parser state
    t_phase      r_phase,      n_phase;
    logic [2:0]  r_step,       n_step;
    logic [7:0]  r_bcnt,       n_bcnt;
    logic [15:0] r_rec,        n_rec;
    logic [7:0]  r_do_total,   n_do_total;
    logic [15:0] r_ape_total,  n_ape_total;
    logic [7:0]  r_data_len,   n_data_len;
    logic [7:0]  r_pair_total, n_pair_total;
    logic [2:0]  r_acc_total,  n_acc_total;
    logic [31:0] r_acc,        n_acc;

    // result buffer, one burst of beats per parsed byte
    t_result     r_res [MAX_RES];
    t_result     n_res [MAX_RES];
    logic [2:0]  r_cnt,        n_cnt;
    logic [1:0]  r_ptr;
    logic        r_done,       n_done;

    logic        in_take;
    logic        out_take;
    logic        out_last;
    logic        parse_fire;

    // gather helper
    logic [7:0]  need;
    logic [31:0] g_val;
    logic [7:0]  g_cnt;
    logic        g_done;

    // record end handling
    logic        asf_end;
    logic        ape_end;
    logic        clear;
    logic        stop;
    logic [15:0] rec_inc;
    logic [7:0]  b;

    t_result     cur;

    // ---------------------------------------------------------------- handshakes
    assign o_valid    = (r_cnt != 3'd0);
    assign out_take   = o_valid && !i_stall;
    assign out_last   = (({1'b0, r_ptr} + 3'd1) == r_cnt);
    // the parse stage may refill the buffer once its last beat leaves
    assign parse_fire = r_in_valid && ((r_cnt == 3'd0) || (out_take && out_last));
    assign o_stall    = r_in_valid && !parse_fire;
    assign in_take    = i_valid && !o_stall;

    assign cur             = r_res[r_ptr];
    assign o_field_code    = cur.code;
    assign o_entity_index  = cur.entity;
    assign o_element_index = cur.element;
    assign o_field_value   = cur.value;
    assign o_last_of_run   = o_valid && out_last;
    assign o_parse_done    = o_valid && out_last && r_done;

    assign b = r_in_byte;

    // ---------------------------------------------------------------- byte count of the field being gathered
    always_comb begin
        case (r_phase)
            PH_HEADER:  need = 8'(HDR_WIDE_BYTES);
            PH_DO:      need = 8'(DO_WIDE_BYTES);
            PH_APE_CNT: need = 8'(APE_COUNT_BYTES);
            PH_APE: begin
                case (r_step)
                    3'd0:    need = 8'(APE_ID_BYTES);
                    3'd1:    need = 8'(OPCODE_BYTES);
                    3'd3:    need = 8'(COST_BYTES);
                    default: need = 8'(TIME_BYTES);
                endcase
            end
            default:    need = 8'd1;
        endcase
    end

    // big-endian assembly, one byte at a time
    assign g_val  = {r_acc[23:0], b};
    assign g_cnt  = r_bcnt + 8'd1;
    assign g_done = (g_cnt >= need);

    // ---------------------------------------------------------------- parse of one byte
    always_comb begin
        n_phase      = r_phase;
        n_step       = r_step;
        n_bcnt       = r_bcnt;
        n_rec        = r_rec;
        n_do_total   = r_do_total;
        n_ape_total  = r_ape_total;
        n_data_len   = r_data_len;
        n_pair_total = r_pair_total;
        n_acc_total  = r_acc_total;
        n_acc        = r_acc;
        for (int k = 0; k < MAX_RES; k++) begin
            n_res[k] = mk_result(F_LCF, 16'd0, 8'd0, 32'd0);
        end
        n_cnt   = 3'd0;
        n_done  = 1'b0;
        asf_end = 1'b0;
        ape_end = 1'b0;
        clear   = 1'b0;
        stop    = 1'b0;
        rec_inc = r_rec + 16'd1;

        case (r_phase)
            PH_HEADER: begin
                case (r_step)
                    3'd0: begin
                        // flag byte: lcf and naf
                        n_res[0] = mk_result(F_LCF, 16'd0, 8'd0, {31'd0, b[7]});
                        n_res[1] = mk_result(F_NAF, 16'd0, 8'd0, {31'd0, b[6]});
                        n_cnt    = 3'd2;
                        n_step   = 3'd1;
                    end
                    3'd1, 3'd2, 3'd3, 3'd4: begin
                        n_res[0] = mk_result(t_field'({2'd0, r_step} + 5'd1), 16'd0, 8'd0,
                                             {24'd0, b});
                        n_cnt    = 3'd1;
                        n_step   = r_step + 3'd1;
                    end
                    3'd5: begin
                        if (g_done) begin
                            n_res[0] = mk_result(F_DEV_ID, 16'd0, 8'd0, g_val);
                            n_cnt    = 3'd1;
                            n_acc    = '0;
                            n_bcnt   = '0;
                            n_step   = 3'd6;
                        end else begin
                            n_acc  = g_val;
                            n_bcnt = g_cnt;
                        end
                    end
                    default: begin
                        if (g_done) begin
                            n_res[0] = mk_result(F_CREATE_DATE, 16'd0, 8'd0, g_val);
                            n_cnt    = 3'd1;
                            n_acc    = '0;
                            n_bcnt   = '0;
                            n_phase  = PH_DO_CNT;
                            n_step   = 3'd0;
                        end else begin
                            n_acc  = g_val;
                            n_bcnt = g_cnt;
                        end
                    end
                endcase
            end

            PH_DO_CNT: begin
                n_do_total = b;
                n_res[0]   = mk_result(F_DO_COUNT, 16'd0, 8'd0, {24'd0, b});
                n_cnt      = 3'd1;
                n_rec      = '0;
                n_step     = 3'd0;
                n_bcnt     = '0;
                // an empty do section goes straight to the ape count
                n_phase    = (b == 8'd0) ? PH_APE_CNT : PH_DO;
            end

            PH_DO: begin
                case (r_step)
                    3'd0: begin
                        n_res[0] = mk_result(F_DO_ID, r_rec, 8'd0, {24'd0, b});
                        n_cnt    = 3'd1;
                        n_step   = 3'd1;
                    end
                    3'd1, 3'd2: begin
                        if (g_done) begin
                            n_res[0] = mk_result((r_step == 3'd1) ? F_DO_SIZE : F_DO_ACCESS_T,
                                                 r_rec, 8'd0, g_val);
                            n_cnt    = 3'd1;
                            n_acc    = '0;
                            n_bcnt   = '0;
                            n_step   = r_step + 3'd1;
                        end else begin
                            n_acc  = g_val;
                            n_bcnt = g_cnt;
                        end
                    end
                    3'd3: begin
                        n_data_len = b;
                        n_res[0]   = mk_result(F_DATA_LEN, r_rec, 8'd0, {24'd0, b});
                        n_cnt      = 3'd1;
                        n_bcnt     = '0;
                        if (b == 8'd0) begin
                            n_phase = PH_ASF;
                            n_step  = 3'd0;
                        end else begin
                            n_step = 3'd4;
                        end
                    end
                    default: begin
                        n_res[0] = mk_result(F_DATA_BYTE, r_rec, r_bcnt, {24'd0, b});
                        n_cnt    = 3'd1;
                        n_bcnt   = g_cnt;
                        if (g_cnt >= r_data_len) begin
                            n_phase = PH_ASF;
                            n_step  = 3'd0;
                            n_bcnt  = '0;
                        end
                    end
                endcase
            end

            PH_ASF: begin
                case (r_step)
                    3'd0: begin
                        n_res[0] = mk_result(F_ASF_DO, r_rec, 8'd0, {24'd0, b});
                        n_cnt    = 3'd1;
                        n_step   = 3'd1;
                    end
                    3'd1: begin
                        n_pair_total = b;
                        n_res[0]     = mk_result(F_PAIR_COUNT, r_rec, 8'd0, {24'd0, b});
                        n_cnt        = 3'd1;
                        n_bcnt       = '0;
                        if (b == 8'd0) begin
                            asf_end = 1'b1;
                        end else begin
                            n_step = 3'd2;
                        end
                    end
                    3'd2: begin
                        n_res[0] = mk_result(F_PAIR_APE, r_rec, r_bcnt, {24'd0, b});
                        n_cnt    = 3'd1;
                        n_step   = 3'd3;
                    end
                    default: begin
                        n_res[0] = mk_result(F_PAIR_PORT, r_rec, r_bcnt, {24'd0, b});
                        n_cnt    = 3'd1;
                        n_bcnt   = g_cnt;
                        if (g_cnt >= r_pair_total) begin
                            asf_end = 1'b1;
                        end else begin
                            n_step = 3'd2;
                        end
                    end
                endcase
            end

            PH_APE_CNT: begin
                if (g_done) begin
                    n_res[0] = mk_result(F_APE_COUNT, 16'd0, 8'd0, g_val);
                    n_cnt    = 3'd1;
                    n_acc    = '0;
                    n_bcnt   = '0;
                    n_rec    = '0;
                    n_step   = 3'd0;
                    // counts beyond 16 bits saturate
                    n_ape_total = (g_val[31:16] != 16'd0) ? 16'hFFFF : g_val[15:0];
                    if (g_val == 32'd0) begin
                        n_done = 1'b1;
                        clear  = 1'b1;
                    end else begin
                        n_phase = PH_APE;
                    end
                end else begin
                    n_acc  = g_val;
                    n_bcnt = g_cnt;
                end
            end

            default: begin
                case (r_step)
                    3'd0, 3'd1, 3'd3: begin
                        if (g_done) begin
                            n_res[0] = mk_result((r_step == 3'd0) ? F_APE_ID :
                                                 (r_step == 3'd1) ? F_OPCODE : F_COST,
                                                 r_rec, 8'd0, g_val);
                            n_cnt    = 3'd1;
                            n_acc    = '0;
                            n_bcnt   = '0;
                            n_step   = r_step + 3'd1;
                        end else begin
                            n_acc  = g_val;
                            n_bcnt = g_cnt;
                        end
                    end
                    3'd2: begin
                        // t/nn byte
                        n_acc_total = b[6:4];
                        n_res[0]    = mk_result(F_T_BIT, r_rec, 8'd0, {31'd0, b[7]});
                        n_res[1]    = mk_result(F_NN, r_rec, 8'd0, {29'd0, b[6:4]});
                        n_cnt       = 3'd2;
                        n_step      = 3'd3;
                    end
                    3'd4: begin
                        if (g_done) begin
                            n_res[0] = mk_result(F_TIME, r_rec, 8'd0, g_val);
                            n_cnt    = 3'd1;
                            n_acc    = '0;
                            n_bcnt   = '0;
                            if (r_acc_total == 3'd0) begin
                                ape_end = 1'b1;
                            end else begin
                                n_step = 3'd5;
                            end
                        end else begin
                            n_acc  = g_val;
                            n_bcnt = g_cnt;
                        end
                    end
                    default: begin
                        // four access types per byte, msb pair first
                        for (int k = 0; k < MAX_RES; k++) begin
                            if (!stop) begin
                                n_res[k] = mk_result(F_ACCESS_TYPE, r_rec, r_bcnt + 8'(k),
                                                     {30'd0, b[(MAX_RES - 1 - k) * 2 +: 2]});
                                n_cnt    = 3'(k + 1);
                                if ((r_bcnt + 8'(k + 1)) >= {5'd0, r_acc_total}) begin
                                    stop = 1'b1;
                                end
                            end
                        end
                        if (stop) begin
                            ape_end = 1'b1;
                        end else begin
                            n_bcnt = r_bcnt + 8'(MAX_RES);
                        end
                    end
                endcase
            end
        endcase

        // end of a do/asf record pair
        if (asf_end) begin
            n_step = 3'd0;
            n_bcnt = '0;
            if (rec_inc >= {8'd0, r_do_total}) begin
                n_phase = PH_APE_CNT;
                n_rec   = '0;
            end else begin
                n_phase = PH_DO;
                n_rec   = rec_inc;
            end
        end

        // end of an ape record, the last one finishes the code
        if (ape_end) begin
            if (rec_inc >= r_ape_total) begin
                n_done = 1'b1;
                clear  = 1'b1;
            end else begin
                n_rec  = rec_inc;
                n_step = 3'd0;
                n_bcnt = '0;
            end
        end

        if (clear) begin
            n_phase      = PH_HEADER;
            n_step       = '0;
            n_bcnt       = '0;
            n_rec        = '0;
            n_do_total   = '0;
            n_ape_total  = '0;
            n_data_len   = '0;
            n_pair_total = '0;
            n_acc_total  = '0;
            n_acc        = '0;
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_HEADER;
            r_step       <= '0;
            r_bcnt       <= '0;
            r_rec        <= '0;
            r_do_total   <= '0;
            r_ape_total  <= '0;
            r_data_len   <= '0;
            r_pair_total <= '0;
            r_acc_total  <= '0;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_ptr        <= '0;
            r_done       <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (parse_fire) begin
                r_in_valid <= 1'b0;
            end

            if (parse_fire) begin
                r_phase      <= n_phase;
                r_step       <= n_step;
                r_bcnt       <= n_bcnt;
                r_rec        <= n_rec;
                r_do_total   <= n_do_total;
                r_ape_total  <= n_ape_total;
                r_data_len   <= n_data_len;
                r_pair_total <= n_pair_total;
                r_acc_total  <= n_acc_total;
                r_acc        <= n_acc;
                r_cnt        <= n_cnt;
                r_ptr        <= '0;
                r_done       <= n_done;
            end else if (out_take) begin
                if (out_last) begin
                    r_cnt <= '0;
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + 2'd1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_cfg_byte;
        end
        if (parse_fire) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTH
    // a burst never claims more beats than the buffer holds
    a_burst_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(MAX_RES))
        else $error("result burst too long");

    // a new byte is parsed only once the previous burst has gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_fire |-> ((r_cnt == 3'd0) || (out_take && out_last)))
        else $error("result buffer overwritten");

    // a burst runs on until its last beat
    a_burst_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("result burst cut short");

    // completion is flagged only on the closing beat of a burst
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_parse_done |-> o_last_of_run)
        else $error("parse done off the last beat");
`endif

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ccsp_pkg::*;

    // stream sections as the parser walks them
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DO_COUNT,
        PH_DO_REC,
        PH_ASF_REC,
        PH_APE_COUNT,
        PH_APE_REC
    } t_parse_phase;

    typedef struct {
        t_field      code;
        logic [15:0] ent;
        logic [7:0]  elem;
        logic [31:0] val;
        logic        last;
        logic        done;
    } t_field_beat;

    typedef struct {
        logic [7:0]  cfg;
        bit          typed;
        t_field      code;
        logic [31:0] val;
    } t_table_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_cfg_byte;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_field_code;
    logic [15:0] o_entity_index;
    logic [7:0]  o_element_index;
    logic [31:0] o_field_value;
    logic        o_last_of_run;
    logic        o_parse_done;

    config_code_stream_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cfg_byte      (i_cfg_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_field_code    (o_field_code),
        .o_entity_index  (o_entity_index),
        .o_element_index (o_element_index),
        .o_field_value   (o_field_value),
        .o_last_of_run   (o_last_of_run),
        .o_parse_done    (o_parse_done)
    );

    // parser state mirrored by the decoder below
    t_parse_phase sec_phase;
    logic [4:0]   fstep;
    logic [7:0]   bcnt;
    logic [15:0]  rec_idx;
    logic [7:0]   do_cnt;
    logic [15:0]  ape_cnt;
    logic [7:0]   dlen;
    logic [7:0]   npairs;
    logic [2:0]   nacc;
    logic [31:0]  acc;
    bit           run_done;

    t_field_beat  byte_beats[$];     // beats caused by the latest byte
    t_field_beat  pending_beats[$];  // beats still owed by the block
    int           err_count = 0;
    bit           zero_ape_seen;
    bit           tx_calm;

    // one walk through a short code: header extremes, no DO records, one APE with NN zero
    t_table_row dir_rows [21] = '{
        '{8'hC0, 1'b1, F_LCF,          32'd1},
        '{8'h00, 1'b1, F_TASK_ID,      32'h00},
        '{8'hFF, 1'b1, F_RPI_VERSION,  32'hFF},
        '{8'h5A, 1'b1, F_REF_ID,       32'h5A},
        '{8'hA5, 1'b1, F_IMPL_VERSION, 32'hA5},
        '{8'hFF, 1'b0, F_LCF,          32'h0},
        '{8'hFF, 1'b1, F_DEV_ID,       32'hFFFF},
        '{8'h00, 1'b0, F_LCF,          32'h0},
        '{8'h00, 1'b1, F_CREATE_DATE,  32'h0000},
        '{8'h00, 1'b1, F_DO_COUNT,     32'd0},
        '{8'h00, 1'b0, F_LCF,          32'h0},
        '{8'h01, 1'b1, F_APE_COUNT,    32'd1},
        '{8'hFF, 1'b0, F_LCF,          32'h0},
        '{8'hFF, 1'b1, F_APE_ID,       32'hFFFF},
        '{8'h00, 1'b0, F_LCF,          32'h0},
        '{8'h00, 1'b1, F_OPCODE,       32'h0000},
        '{8'h80, 1'b1, F_T_BIT,        32'd1},
        '{8'h12, 1'b0, F_LCF,          32'h0},
        '{8'h34, 1'b1, F_COST,         32'h1234},
        '{8'h00, 1'b0, F_LCF,          32'h0},
        '{8'h07, 1'b1, F_TIME,         32'h0007}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // generous bound on the whole run
    initial begin
        #10_000_000;
        $display("config_code_stream_parser verification failed");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic clear_parse_state();
        sec_phase = PH_HEADER;
        fstep     = '0;
        bcnt      = '0;
        rec_idx   = '0;
        do_cnt    = '0;
        ape_cnt   = '0;
        dlen      = '0;
        npairs    = '0;
        nacc      = '0;
        acc       = '0;
    endtask

    task automatic add_beat(input t_field code, input logic [15:0] ent,
                            input logic [7:0] elem, input logic [31:0] val);
        t_field_beat fb;
        fb.code = code;
        fb.ent  = ent;
        fb.elem = elem;
        fb.val  = val;
        fb.last = 1'b0;
        fb.done = 1'b0;
        if (byte_beats.size() < MAX_RES) byte_beats.push_back(fb);
    endtask

    // big-endian gather of a multi-byte field, true once n bytes are in
    function automatic bit collect(input int unsigned n, input logic [7:0] b,
                                   output logic [31:0] v);
        acc  = {acc[23:0], b};
        bcnt = bcnt + 8'd1;
        v    = acc;
        if (bcnt >= n) begin
            acc  = '0;
            bcnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic next_do_record();
        rec_idx = rec_idx + 16'd1;
        if (rec_idx >= {8'd0, do_cnt}) begin
            sec_phase = PH_APE_COUNT;
            rec_idx   = '0;
        end else begin
            sec_phase = PH_DO_REC;
        end
        fstep = '0;
        bcnt  = '0;
    endtask

    task automatic close_ape_record();
        rec_idx = rec_idx + 16'd1;
        if (rec_idx >= ape_cnt) begin
            run_done = 1'b1;
            clear_parse_state();
        end else begin
            fstep = '0;
            bcnt  = '0;
        end
    endtask

    // works out the beats that one accepted byte causes and queues them
    task automatic decode_cfg_byte(input logic [7:0] b);
        logic [31:0] v;
        byte_beats.delete();
        run_done = 1'b0;
        case (sec_phase)
            PH_HEADER: begin
                case (fstep)
                    5'd0: begin
                        add_beat(F_LCF, '0, '0, {31'd0, b[7]});
                        add_beat(F_NAF, '0, '0, {31'd0, b[6]});
                        fstep = 5'd1;
                    end
                    5'd1: begin
                        add_beat(F_TASK_ID, '0, '0, {24'd0, b});
                        fstep = 5'd2;
                    end
                    5'd2: begin
                        add_beat(F_RPI_VERSION, '0, '0, {24'd0, b});
                        fstep = 5'd3;
                    end
                    5'd3: begin
                        add_beat(F_REF_ID, '0, '0, {24'd0, b});
                        fstep = 5'd4;
                    end
                    5'd4: begin
                        add_beat(F_IMPL_VERSION, '0, '0, {24'd0, b});
                        fstep = 5'd5;
                    end
                    5'd5: begin
                        if (collect(HDR_WIDE_BYTES, b, v)) begin
                            add_beat(F_DEV_ID, '0, '0, v);
                            fstep = 5'd6;
                        end
                    end
                    default: begin
                        if (collect(HDR_WIDE_BYTES, b, v)) begin
                            add_beat(F_CREATE_DATE, '0, '0, v);
                            sec_phase = PH_DO_COUNT;
                            fstep     = '0;
                        end
                    end
                endcase
            end
            PH_DO_COUNT: begin
                do_cnt = b;
                add_beat(F_DO_COUNT, '0, '0, {24'd0, b});
                rec_idx   = '0;
                fstep     = '0;
                bcnt      = '0;
                // zero count skips straight to the ape count
                sec_phase = (b == 8'd0) ? PH_APE_COUNT : PH_DO_REC;
            end
            PH_DO_REC: begin
                case (fstep)
                    5'd0: begin
                        add_beat(F_DO_ID, rec_idx, '0, {24'd0, b});
                        fstep = 5'd1;
                    end
                    5'd1: begin
                        if (collect(DO_WIDE_BYTES, b, v)) begin
                            add_beat(F_DO_SIZE, rec_idx, '0, v);
                            fstep = 5'd2;
                        end
                    end
                    5'd2: begin
                        if (collect(DO_WIDE_BYTES, b, v)) begin
                            add_beat(F_DO_ACCESS_T, rec_idx, '0, v);
                            fstep = 5'd3;
                        end
                    end
                    5'd3: begin
                        dlen = b;
                        add_beat(F_DATA_LEN, rec_idx, '0, {24'd0, b});
                        if (b == 8'd0) begin
                            sec_phase = PH_ASF_REC;
                            fstep     = '0;
                            bcnt      = '0;
                        end else begin
                            fstep = 5'd4;
                            bcnt  = '0;
                        end
                    end
                    default: begin
                        add_beat(F_DATA_BYTE, rec_idx, bcnt, {24'd0, b});
                        bcnt = bcnt + 8'd1;
                        if (bcnt >= dlen) begin
                            sec_phase = PH_ASF_REC;
                            fstep     = '0;
                            bcnt      = '0;
                        end
                    end
                endcase
            end
            PH_ASF_REC: begin
                case (fstep)
                    5'd0: begin
                        add_beat(F_ASF_DO, rec_idx, '0, {24'd0, b});
                        fstep = 5'd1;
                    end
                    5'd1: begin
                        npairs = b;
                        add_beat(F_PAIR_COUNT, rec_idx, '0, {24'd0, b});
                        if (b == 8'd0) begin
                            next_do_record();
                        end else begin
                            fstep = 5'd2;
                            bcnt  = '0;
                        end
                    end
                    5'd2: begin
                        add_beat(F_PAIR_APE, rec_idx, bcnt, {24'd0, b});
                        fstep = 5'd3;
                    end
                    default: begin
                        add_beat(F_PAIR_PORT, rec_idx, bcnt, {24'd0, b});
                        bcnt = bcnt + 8'd1;
                        if (bcnt >= npairs) next_do_record();
                        else fstep = 5'd2;
                    end
                endcase
            end
            PH_APE_COUNT: begin
                if (collect(APE_COUNT_BYTES_DEF, b, v)) begin
                    add_beat(F_APE_COUNT, '0, '0, v);
                    // saturating record count, the beat keeps the full value
                    ape_cnt = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
                    rec_idx = '0;
                    fstep   = '0;
                    bcnt    = '0;
                    if (ape_cnt == 16'd0) begin
                        run_done = 1'b1;
                        clear_parse_state();
                    end else begin
                        sec_phase = PH_APE_REC;
                    end
                end
            end
            default: begin
                case (fstep)
                    5'd0: begin
                        if (collect(APE_ID_BYTES_DEF, b, v)) begin
                            add_beat(F_APE_ID, rec_idx, '0, v);
                            fstep = 5'd1;
                        end
                    end
                    5'd1: begin
                        if (collect(OPCODE_BYTES_DEF, b, v)) begin
                            add_beat(F_OPCODE, rec_idx, '0, v);
                            fstep = 5'd2;
                        end
                    end
                    5'd2: begin
                        nacc = b[6:4];
                        add_beat(F_T_BIT, rec_idx, '0, {31'd0, b[7]});
                        add_beat(F_NN, rec_idx, '0, {29'd0, b[6:4]});
                        fstep = 5'd3;
                    end
                    5'd3: begin
                        if (collect(COST_BYTES_DEF, b, v)) begin
                            add_beat(F_COST, rec_idx, '0, v);
                            fstep = 5'd4;
                        end
                    end
                    5'd4: begin
                        if (collect(TIME_BYTES_DEF, b, v)) begin
                            add_beat(F_TIME, rec_idx, '0, v);
                            if (nacc == 3'd0) begin
                                close_ape_record();
                            end else begin
                                fstep = 5'd5;
                                bcnt  = '0;
                            end
                        end
                    end
                    default: begin
                        // four access types per byte, msb pair first, spares dropped
                        for (int sh = 6; sh >= 0; sh -= 2) begin
                            add_beat(F_ACCESS_TYPE, rec_idx, bcnt, {30'd0, b[sh +: 2]});
                            bcnt = bcnt + 8'd1;
                            if (bcnt >= {5'd0, nacc}) begin
                                close_ape_record();
                                break;
                            end
                        end
                    end
                endcase
            end
        endcase
        if (byte_beats.size() > 0) begin
            byte_beats[byte_beats.size() - 1].last = 1'b1;
            byte_beats[byte_beats.size() - 1].done = run_done;
        end
        foreach (byte_beats[k]) pending_beats.push_back(byte_beats[k]);
    endtask

    // next byte of a well-formed code: counts and lengths kept small, rare long ones
    function automatic logic [7:0] pick_cfg_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case (sec_phase)
            PH_DO_COUNT: b = 8'($urandom_range(0, 3));
            PH_DO_REC: begin
                if (fstep == 5'd3 && $urandom_range(0, 39) != 0)
                    b = 8'($urandom_range(0, 4));
            end
            PH_ASF_REC: begin
                if (fstep == 5'd1 && $urandom_range(0, 39) != 0)
                    b = 8'($urandom_range(0, 3));
            end
            PH_APE_COUNT: begin
                if (bcnt != 8'(APE_COUNT_BYTES_DEF - 1)) begin
                    b = 8'd0;
                end else if (!zero_ape_seen) begin
                    b = 8'd0;
                    zero_ape_seen = 1'b1;
                end else begin
                    b = 8'($urandom_range(0, 3));
                end
            end
            default: ;
        endcase
        return b;
    endfunction

    // offer one byte after a random gap, decode it once the block takes it
    task automatic send_cfg_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cfg_byte <= b;
        do @(posedge i_clk); while (o_stall);
        decode_cfg_byte(b);
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    endtask

    initial begin
        int sent;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cfg_byte = 8'd0;
        zero_ape_seen = 1'b0;
        tx_calm    = 1'b0;
        clear_parse_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, typed values checked against the decoder's first beat
        for (int i = 0; i < $size(dir_rows); i++) begin
            send_cfg_byte(dir_rows[i].cfg);
            if (dir_rows[i].typed) begin
                if (byte_beats.size() == 0) begin
                    note_mismatch("table row gave no beat", i, dir_rows[i].code);
                end else begin
                    if (byte_beats[0].code != dir_rows[i].code)
                        note_mismatch("table row code", byte_beats[0].code, dir_rows[i].code);
                    if (byte_beats[0].val != dir_rows[i].val)
                        note_mismatch("table row value", byte_beats[0].val, dir_rows[i].val);
                end
            end
        end

        // random codes, stopping only on a code boundary
        sent = 0;
        while (sent < 120 || sec_phase != PH_HEADER || fstep != 5'd0) begin
            send_cfg_byte(pick_cfg_byte());
            sent++;
        end
        i_valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_beats.size() == 0)
            $display("config_code_stream_parser verification clean");
        else
            $display("config_code_stream_parser verification failed");
        $finish;
    end

    // receiver: random stalls, calm stretches and one long hold-off
    initial begin
        int n;
        int taken;
        bit rx_calm;
        i_stall = 1'b0;
        taken   = 0;
        rx_calm = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken == 25) begin
                i_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                n = rx_calm ? 0 : $urandom_range(0, 4);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
            do @(posedge i_clk); while (!o_valid);
            taken++;
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        end
    end

    // compare each taken beat with the oldest one owed
    always @(posedge i_clk) begin
        t_field_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                note_mismatch("beat with nothing pending", o_field_code, '0);
            end else begin
                want = pending_beats.pop_front();
                if (o_field_code != want.code)
                    note_mismatch("field_code", o_field_code, want.code);
                if (o_entity_index != want.ent)
                    note_mismatch("entity_index", o_entity_index, want.ent);
                if (o_element_index != want.elem)
                    note_mismatch("element_index", o_element_index, want.elem);
                if (o_field_value != want.val)
                    note_mismatch("field_value", o_field_value, want.val);
                if (o_last_of_run != want.last)
                    note_mismatch("last_of_run", o_last_of_run, want.last);
                if (o_parse_done != want.done)
                    note_mismatch("parse_done", o_parse_done, want.done);
            end
        end
    end

endmodule
